// ===== hdl/mdc_pkg.sv =====
// Shared types and constants for the microphone DC-block conditioner.
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

    localparam int RAW_W      = 32;
    localparam int SAMPLE_W   = 24;
    localparam int OUT_W      = 16;
    localparam int Y_W        = 48;
    localparam int SHIFT_W    = 5;
    localparam int LEVEL_W    = 23;
    localparam int COEFF_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_GAIN_SHIFT   = 4'd0;
    localparam cfg_idx_t CFG_GLITCH_LEVEL = 4'd1;
    localparam cfg_idx_t CFG_QUIET_LEVEL  = 4'd2;
    localparam cfg_idx_t CFG_POLE_COEFF   = 4'd3;

    localparam logic [SHIFT_W-1:0] GAIN_SHIFT_RST   = 5'd13;
    localparam logic [SHIFT_W-1:0] GAIN_SHIFT_MIN   = 5'd8;
    localparam logic [LEVEL_W-1:0] GLITCH_LEVEL_RST = 23'd28000;
    localparam logic [LEVEL_W-1:0] QUIET_LEVEL_RST  = 23'd5000;
    localparam logic [COEFF_W-1:0] POLE_COEFF_RST   = 16'd65208;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    // Magnitude of a signed sample; the most negative value maps to 2^23
    function automatic logic [SAMPLE_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] m;
        begin
            m = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mdc_if.sv =====
// Stream and configuration channel interfaces of the conditioner.
`timescale 1ns / 1ps
`default_nettype none

interface mdc_mic_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mdc_pkg::RAW_W-1:0]        raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

interface mdc_pcm_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mdc_pkg::OUT_W-1:0]        sample_out;
    logic                                    clipped;
    logic                                    glitch_replaced;

    modport source (output valid, output sample_out, output clipped,
                    output glitch_replaced, input ready);
    modport sink   (input valid, input sample_out, input clipped,
                    input glitch_replaced, output ready);
endinterface

interface mdc_cfg_if;
    logic                                    valid;
    logic                                    ready;
    mdc_pkg::cfg_idx_t                       index;
    logic [mdc_pkg::CFG_DATA_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mic_sample_dc_block_conditioner_top.sv =====
// Top level: gain shift, glitch suppression and one-pole DC blocker.
//
//   Channel | Role   | Payload
//   --------+--------+-----------------------------------------------
//   mic     | sink   | raw_word (32b signed)
//   pcm     | source | sample_out (16b signed), clipped, glitch_replaced
//   cfg     | sink   | index (4b), data (32b); always ready
//
// One request per cycle sustained while pcm.ready holds; an accepted request is held in the
// input register, then moves into the result register, from which pcm hands it over.
// The filter recurrence (48x17 multiply, add, saturate) is combinational between the
// input register and the result register.
// Reset clears both stages, the filter state and loads the register defaults.
// A stalled result holds the result register; the input register still takes one more
// request, then mic.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module mic_sample_dc_block_conditioner_top #(
    parameter int COEFF_FRAC_BITS = 16,
    parameter int STATE_FRAC_BITS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    mdc_mic_if.sink      mic,
    mdc_pcm_if.source    pcm,
    mdc_cfg_if.sink      cfg
);

    localparam int SW     = mdc_pkg::SAMPLE_W;
    localparam int YW     = mdc_pkg::Y_W;
    localparam int OW     = mdc_pkg::OUT_W;
    localparam int PROD_W = YW + mdc_pkg::COEFF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TW     = YW + 1;

    // Configuration registers
    logic [mdc_pkg::SHIFT_W-1:0] gain_shift_reg;
    logic [mdc_pkg::LEVEL_W-1:0] glitch_level_reg;
    logic [mdc_pkg::LEVEL_W-1:0] quiet_level_reg;
    logic [mdc_pkg::COEFF_W-1:0] pole_coeff_reg;

    // Pipeline and filter state
    logic                         s1_valid_reg;
    logic signed [mdc_pkg::RAW_W-1:0] s1_raw_reg;
    logic signed [SW-1:0]         last_sample_reg;   // also the filter's x1
    logic signed [YW-1:0]         prev_output_reg;
    logic                         out_valid_reg;
    logic signed [OW-1:0]         sample_reg;
    logic                         clipped_reg;
    logic                         glitch_reg;

    logic                         advance;

    logic [mdc_pkg::SHIFT_W-1:0]  sh;
    logic signed [mdc_pkg::RAW_W-1:0] shifted;
    logic signed [SW-1:0]         x_shift;
    logic                         glitch;
    logic signed [SW-1:0]         x_next;
    logic signed [SW:0]           dx;
    logic signed [SUM_W-1:0]      dx_term;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     prod_sh;
    logic signed [SUM_W-1:0]      y_sum;
    logic                         y_ovf_pos;
    logic                         y_ovf_neg;
    logic signed [YW-1:0]         y_next;
    logic [TW-1:0]                bias;
    logic signed [TW-1:0]         y_biased;
    logic signed [TW-1:0]         s_trunc;
    logic                         s_ovf_pos;
    logic                         s_ovf_neg;
    logic signed [OW-1:0]         sample_next;
    logic                         clipped_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_shift_reg   <= mdc_pkg::GAIN_SHIFT_RST;
            glitch_level_reg <= mdc_pkg::GLITCH_LEVEL_RST;
            quiet_level_reg  <= mdc_pkg::QUIET_LEVEL_RST;
            pole_coeff_reg   <= mdc_pkg::POLE_COEFF_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mdc_pkg::CFG_GAIN_SHIFT:
                    gain_shift_reg <= cfg.data[mdc_pkg::SHIFT_W-1:0];
                mdc_pkg::CFG_GLITCH_LEVEL:
                    glitch_level_reg <= cfg.data[mdc_pkg::LEVEL_W-1:0];
                mdc_pkg::CFG_QUIET_LEVEL:
                    quiet_level_reg <= cfg.data[mdc_pkg::LEVEL_W-1:0];
                mdc_pkg::CFG_POLE_COEFF:
                    pole_coeff_reg <= cfg.data[mdc_pkg::COEFF_W-1:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Move the held request into the result register when that register is free
    assign advance   = s1_valid_reg && (!out_valid_reg || pcm.ready);
    assign mic.ready = !s1_valid_reg || advance;

    // Gain shift; small shifts act as the minimum so the sample fits 24 bits
    always_comb
    begin
        sh      = (gain_shift_reg < mdc_pkg::GAIN_SHIFT_MIN) ? mdc_pkg::GAIN_SHIFT_MIN
                                                              : gain_shift_reg;
        shifted = s1_raw_reg >>> sh;
        x_shift = shifted[SW-1:0];
        glitch  = (mdc_pkg::mag(x_shift) >= {1'b0, glitch_level_reg}) &&
                  (mdc_pkg::mag(last_sample_reg) < {1'b0, quiet_level_reg});
        x_next  = glitch ? last_sample_reg : x_shift;
    end

    // DC blocker: y = (x - x1) * 2^S + floor(R * y1 / 2^C), clamped to 48 bits
    always_comb
    begin
        dx        = {x_next[SW-1], x_next} - {last_sample_reg[SW-1], last_sample_reg};
        dx_term   = SUM_W'(dx) <<< STATE_FRAC_BITS;
        prod      = $signed(prev_output_reg) * $signed({1'b0, pole_coeff_reg});
        prod_sh   = prod >>> COEFF_FRAC_BITS;
        y_sum     = dx_term + SUM_W'(prod_sh);
        y_ovf_pos = !y_sum[SUM_W-1] && (|y_sum[SUM_W-2:YW-1]);
        y_ovf_neg = y_sum[SUM_W-1] && !(&y_sum[SUM_W-2:YW-1]);
        if (y_ovf_pos)
        begin
            y_next = mdc_pkg::Y_MAX;
        end
        else if (y_ovf_neg)
        begin
            y_next = mdc_pkg::Y_MIN;
        end
        else
        begin
            y_next = y_sum[YW-1:0];
        end
    end

    // Truncate toward zero: bias negative values before the arithmetic shift
    always_comb
    begin
        bias      = y_next[YW-1] ? TW'((TW'(1) << STATE_FRAC_BITS) - TW'(1)) : '0;
        y_biased  = {y_next[YW-1], y_next} + $signed(bias);
        s_trunc   = y_biased >>> STATE_FRAC_BITS;
        s_ovf_pos = !s_trunc[TW-1] && (|s_trunc[TW-2:OW-1]);
        s_ovf_neg = s_trunc[TW-1] && !(&s_trunc[TW-2:OW-1]);
        clipped_next = s_ovf_pos || s_ovf_neg;
        if (s_ovf_pos)
        begin
            sample_next = mdc_pkg::OUT_MAX;
        end
        else if (s_ovf_neg)
        begin
            sample_next = mdc_pkg::OUT_MIN;
        end
        else
        begin
            sample_next = s_trunc[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_sample_reg <= '0;
            prev_output_reg <= '0;
        end
        else
        begin
            if (mic.valid && mic.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                last_sample_reg <= x_next;
                prev_output_reg <= y_next;
            end
            else if (pcm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mic.valid && mic.ready)
        begin
            s1_raw_reg <= mic.raw_word;
        end
        if (advance)
        begin
            sample_reg  <= sample_next;
            clipped_reg <= clipped_next;
            glitch_reg  <= glitch;
        end
    end

    assign pcm.valid           = out_valid_reg;
    assign pcm.sample_out      = sample_reg;
    assign pcm.clipped         = clipped_reg;
    assign pcm.glitch_replaced = glitch_reg;

    // A clipped result sits at one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clipped_reg |->
            (sample_reg == mdc_pkg::OUT_MAX) || (sample_reg == mdc_pkg::OUT_MIN))
        else $error("clipped result not at a rail");

    // A replaced sample leaves the stored sample unchanged
    a_glitch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && glitch |=> $stable(last_sample_reg))
        else $error("glitch replacement changed last sample");

    // Filter state moves only when a request completes
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(prev_output_reg) && $stable(last_sample_reg))
        else $error("filter state changed without a request");

    // A stalled input stage keeps its request
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_raw_reg))
        else $error("input stage lost a request");

    // An empty result register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> mic.ready)
        else $error("input stalled with free result register");

endmodule

`default_nettype wire
